// File: sv/smt_pkg.sv
// ---------------------------------------------------------------------------
// smt_pkg: shared codes for the sampling multiset table
// Operation and status codes used by the top level and its port checker.
// ---------------------------------------------------------------------------
package smt_pkg;

  // Operation codes of an input word.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;

  // Status codes of a result word.
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  // Packed word widths on the stream ports.
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 40;

endpackage

// File: sv/smt_ram.sv
// ---------------------------------------------------------------------------
// smt_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module smt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/sampling_multiset_table.sv
// ---------------------------------------------------------------------------
// sampling_multiset_table: multiset with insert, remove and random sample
// Values sit in a dense slot array; a head table points at the newest copy
// of each distinct value and slot links chain the older copies.
// ---------------------------------------------------------------------------
//  channel | direction | words
//  in_*    | slave     | one operation per word
//  out_*   | master    | one result per operation
//
// Insert and remove time is set by the head-table scan through one RAM read
// port per cycle, and remove adds a second head-table scan and a scan over
// the slot links. Sample time is set by the 32-step shift-subtract modulo
// unit. After reset a clearing pass over all CAPACITY entries zeroes the
// head valid RAM before the first word is taken. One word is worked at a
// time; the result waits in its register until out_tready.
module sampling_multiset_table #(
  parameter int CAPACITY = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // op [1:0], value [33:2], random_word [65:34], zero pad [71:66]
  input  logic [71:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // answer_flag [0], sampled_value [32:1], status [34:33], zero pad [39:35]
  output logic [39:0] out_tdata
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  typedef enum logic [15:0] {
    S_CLEAR  = 16'h0001, S_IDLE  = 16'h0002, S_FIND   = 16'h0004,
    S_INS_RD = 16'h0008, S_INS_WR = 16'h0010, S_REM_A = 16'h0020,
    S_REM_B  = 16'h0040, S_REM_C = 16'h0080, S_REM_D  = 16'h0100,
    S_HSCAN  = 16'h0200, S_LSCAN = 16'h0400, S_MOVE   = 16'h0800,
    S_MOD    = 16'h1000, S_SRD   = 16'h2000, S_SGET   = 16'h4000,
    S_OUT    = 16'h8000
  } state_t;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [31:0]      val_r, val_nxt;
  logic [31:0]      rnd_r, rnd_nxt;
  logic [IDX_W-1:0] h_r, h_nxt;
  logic             found_r, found_nxt;
  logic             free_r, free_nxt;
  logic [IDX_W-1:0] freeh_r, freeh_nxt;
  logic [IDX_W-1:0] hole_r, hole_nxt;
  logic [IDX_W-1:0] last_r, last_nxt;
  logic [31:0]      mval_r, mval_nxt;
  logic [CNT_W-1:0] mlink_r, mlink_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic [IDX_W-1:0] cmp_r, cmp_nxt;
  logic             cmpv_r, cmpv_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [4:0]       bit_r, bit_nxt;
  logic             flag_r, flag_nxt;
  logic [31:0]      samp_r, samp_nxt;
  logic [1:0]       stat_r, stat_nxt;

  // RAM ports.
  logic             v_we, l_we, k_we, s_we, hv_we;
  logic [IDX_W-1:0] v_wa, l_wa, k_wa, s_wa, hv_wa;
  logic [IDX_W-1:0] v_ra, l_ra, k_ra, s_ra, hv_ra;
  logic [31:0]      v_wd, v_rd, k_rd;
  logic [CNT_W-1:0] l_wd, l_rd;
  logic [IDX_W-1:0] s_wd, s_rd;
  logic             hv_wd, hv_rd;

  logic [CNT_W-1:0] scan_lim;
  logic [CNT_W:0]   rem_sh;
  logic             in_acc;

  smt_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_value (
    .clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(v_rd));
  smt_ram #(.WIDTH(CNT_W), .DEPTH(CAPACITY)) u_link (
    .clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd));
  smt_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_key (
    .clk(clk), .we(k_we), .waddr(k_wa), .wdata(val_r), .raddr(k_ra), .rdata(k_rd));
  smt_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_hslot (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
  smt_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_hvalid (
    .clk(clk), .we(hv_we), .waddr(hv_wa), .wdata(hv_wd), .raddr(hv_ra), .rdata(hv_rd));

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {5'd0, stat_r, samp_r, flag_r};
  assign scan_lim   = (state_r == S_LSCAN) ? CNT_W'(last_r) : CAP_C;
  assign rem_sh     = {rem_r, rnd_r[31]};

  // Sequencer, shared scan engine, modulo unit and RAM port steering.
  always_comb begin
    state_nxt = state_r;  count_nxt = count_r;  op_nxt = op_r;
    val_nxt = val_r;      rnd_nxt = rnd_r;      h_nxt = h_r;
    found_nxt = found_r;  free_nxt = free_r;    freeh_nxt = freeh_r;
    hole_nxt = hole_r;    last_nxt = last_r;    mval_nxt = mval_r;
    mlink_nxt = mlink_r;  scan_nxt = scan_r;    cmp_nxt = cmp_r;
    cmpv_nxt = cmpv_r;    rem_nxt = rem_r;      bit_nxt = bit_r;
    flag_nxt = flag_r;    samp_nxt = samp_r;    stat_nxt = stat_r;
    v_we = 1'b0;  v_wa = count_r[IDX_W-1:0];  v_wd = val_r;
    l_we = 1'b0;  l_wa = count_r[IDX_W-1:0];  l_wd = CAP_C;
    k_we = 1'b0;  k_wa = freeh_r;
    s_we = 1'b0;  s_wa = h_r;  s_wd = count_r[IDX_W-1:0];
    hv_we = 1'b0; hv_wa = freeh_r; hv_wd = 1'b1;
    v_ra = last_r;  l_ra = scan_r[IDX_W-1:0];
    k_ra = scan_r[IDX_W-1:0];  s_ra = scan_r[IDX_W-1:0];
    hv_ra = scan_r[IDX_W-1:0];

    // Pipelined scan: address issued one cycle, compared the next.
    if (state_r == S_FIND || state_r == S_HSCAN || state_r == S_LSCAN) begin
      if (scan_r < scan_lim) begin
        cmp_nxt  = scan_r[IDX_W-1:0];
        cmpv_nxt = 1'b1;
        scan_nxt = scan_r + 1'b1;
      end else begin
        cmpv_nxt = 1'b0;
      end
    end

    unique case (state_r)
      S_CLEAR: begin
        hv_we = 1'b1;
        hv_wa = scan_r[IDX_W-1:0];
        hv_wd = 1'b0;
        scan_nxt = scan_r + 1'b1;
        if (scan_r == CAP_C - 1'b1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          op_nxt = in_tdata[1:0];
          val_nxt = in_tdata[33:2];
          rnd_nxt = in_tdata[65:34];
          flag_nxt = 1'b0;
          samp_nxt = '0;
          stat_nxt = smt_pkg::ST_DONE;
          scan_nxt = '0;
          cmpv_nxt = 1'b0;
          found_nxt = 1'b0;
          free_nxt = 1'b0;
          rem_nxt = '0;
          bit_nxt = '0;
          last_nxt = IDX_W'(count_r - 1'b1);
          unique case (in_tdata[1:0])
            smt_pkg::OP_INSERT: begin
              if (count_r == CAP_C) begin
                stat_nxt = smt_pkg::ST_FULL;
                state_nxt = S_OUT;
              end else begin
                state_nxt = S_FIND;
              end
            end
            smt_pkg::OP_REMOVE: state_nxt = S_FIND;
            smt_pkg::OP_SAMPLE: begin
              if (count_r == '0) begin
                stat_nxt = smt_pkg::ST_EMPTY;
                state_nxt = S_OUT;
              end else begin
                state_nxt = S_MOD;
              end
            end
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_FIND: begin
        if (cmpv_r && hv_rd && k_rd == val_r) begin
          found_nxt = 1'b1;
          h_nxt = cmp_r;
          state_nxt = (op_r == smt_pkg::OP_INSERT) ? S_INS_RD : S_REM_A;
        end else begin
          if (cmpv_r && !hv_rd && !free_r) begin
            free_nxt = 1'b1;
            freeh_nxt = cmp_r;
          end
          if (!cmpv_r && scan_r == CAP_C) begin
            state_nxt = (op_r == smt_pkg::OP_INSERT) ? S_INS_RD : S_OUT;
          end
        end
      end
      S_INS_RD: begin
        s_ra = h_r;
        state_nxt = S_INS_WR;
      end
      S_INS_WR: begin
        v_we = 1'b1;
        l_we = 1'b1;
        if (found_r) begin
          l_wd = CNT_W'(s_rd);
          s_we = 1'b1;
        end else begin
          flag_nxt = 1'b1;
          if (free_r) begin
            hv_we = 1'b1;
            k_we = 1'b1;
            s_we = 1'b1;
            s_wa = freeh_r;
          end
        end
        count_nxt = count_r + 1'b1;
        state_nxt = S_OUT;
      end
      S_REM_A: begin
        s_ra = h_r;
        flag_nxt = 1'b1;
        state_nxt = S_REM_B;
      end
      S_REM_B: begin
        hole_nxt = s_rd;
        l_ra = s_rd;
        state_nxt = S_REM_C;
      end
      S_REM_C: begin
        mval_nxt = v_rd;
        if (l_rd < CAP_C) begin
          s_we = 1'b1;
          s_wd = l_rd[IDX_W-1:0];
        end else begin
          hv_we = 1'b1;
          hv_wa = h_r;
          hv_wd = 1'b0;
        end
        l_ra = last_r;
        state_nxt = S_REM_D;
      end
      S_REM_D: begin
        mlink_nxt = l_rd;
        scan_nxt = '0;
        cmpv_nxt = 1'b0;
        if (hole_r == last_r) begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_HSCAN;
        end
      end
      S_HSCAN: begin
        // Re-point any head that names the last slot.
        if (cmpv_r && hv_rd && s_rd == last_r) begin
          s_we = 1'b1;
          s_wa = cmp_r;
          s_wd = hole_r;
        end
        if (!cmpv_r && scan_r == CAP_C) begin
          scan_nxt = '0;
          state_nxt = S_LSCAN;
        end
      end
      S_LSCAN: begin
        // Re-point any older link that names the last slot.
        if (cmpv_r && cmp_r != hole_r && l_rd == CNT_W'(last_r)) begin
          l_we = 1'b1;
          l_wa = cmp_r;
          l_wd = CNT_W'(hole_r);
        end
        if (!cmpv_r && scan_r == CNT_W'(last_r)) begin
          state_nxt = S_MOVE;
        end
      end
      S_MOVE: begin
        v_we = 1'b1;
        v_wa = hole_r;
        v_wd = mval_r;
        l_we = 1'b1;
        l_wa = hole_r;
        l_wd = mlink_r;
        count_nxt = count_r - 1'b1;
        state_nxt = S_OUT;
      end
      S_MOD: begin
        // One restoring step of random_word mod count per cycle.
        if (rem_sh >= {1'b0, count_r}) begin
          rem_nxt = CNT_W'(rem_sh - {1'b0, count_r});
        end else begin
          rem_nxt = rem_sh[CNT_W-1:0];
        end
        rnd_nxt = {rnd_r[30:0], 1'b0};
        bit_nxt = bit_r + 1'b1;
        if (bit_r == 5'd31) begin
          state_nxt = S_SRD;
        end
      end
      S_SRD: begin
        v_ra = rem_r[IDX_W-1:0];
        state_nxt = S_SGET;
      end
      S_SGET: begin
        samp_nxt = v_rd;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      count_r <= '0;
      scan_r  <= '0;
      cmpv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      scan_r  <= scan_nxt;
      cmpv_r  <= cmpv_nxt;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    op_r <= op_nxt;       val_r <= val_nxt;     rnd_r <= rnd_nxt;
    h_r <= h_nxt;         found_r <= found_nxt; free_r <= free_nxt;
    freeh_r <= freeh_nxt; hole_r <= hole_nxt;   last_r <= last_nxt;
    mval_r <= mval_nxt;   mlink_r <= mlink_nxt; cmp_r <= cmp_nxt;
    rem_r <= rem_nxt;     bit_r <= bit_nxt;     flag_r <= flag_nxt;
    samp_r <= samp_nxt;   stat_r <= stat_nxt;
  end

endmodule

// File: sv/smt_checker.sv
// ---------------------------------------------------------------------------
// smt_checker: port-level checks for the sampling multiset table
// Watches the stream ports and is bound to the top level.
// ---------------------------------------------------------------------------
module smt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [71:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // One word in flight: after an accept the input side closes.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word taken while busy");

  // Input is never open while a result waits.
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("ready with a pending result");

  // A delivered result is not shown again.
  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> !out_tvalid)
    else $error("result repeated");

  // Status never carries the unused code.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[34:33] != smt_pkg::ST_BAD)
    else $error("illegal status code");

endmodule

bind sampling_multiset_table smt_checker u_smt_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .in_tdata(in_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata));

// File: test/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: stream-level test of the sampling multiset table
// Drives insert, remove and sample words into the block and checks every
// result word against a behavioral multiset predictor kept in this bench.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = 256;
  localparam int SLOT_NONE = CAP;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [31:0] rnd;
    logic [31:0] value;
    logic [1:0]  op;
  } op_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] sampled;
    logic        flag;
  } result_word_t;

  // Directed row: operation plus an optional typed-in answer.
  typedef struct {
    op_word_t     w;
    bit           fixed;
    result_word_t res;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  sampling_multiset_table #(.CAPACITY(CAP)) DUT (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state: dense slots, head table, older-copy links.
  logic [31:0] slot_val [CAP];
  int          slot_link [CAP];
  logic [31:0] hd_key [CAP];
  int          hd_slot [CAP];
  bit          hd_valid [CAP];
  int          live_count;

  result_word_t pending_results[$];
  int  mismatch_count = 0;
  bit  hold_off_rx = 1'b0;
  bit  rx_no_idle = 1'b0;
  bit  tx_no_idle = 1'b0;
  longint cycle_count = 0;

  function automatic int head_of(logic [31:0] key);
    for (int i = 0; i < CAP; i++)
      if (hd_valid[i] && hd_key[i] == key) return i;
    return CAP;
  endfunction

  // Apply one operation to the predictor and return the answer it gives.
  function automatic result_word_t multiset_apply(op_word_t w);
    result_word_t r;
    int h;
    int hole;
    int last;
    int older;
    r = '0;
    case (w.op)
      smt_pkg::OP_INSERT: begin
        if (live_count >= CAP) begin
          r.status = smt_pkg::ST_FULL;
        end else begin
          h = head_of(w.value);
          if (h < CAP) begin
            slot_link[live_count] = hd_slot[h];
            hd_slot[h] = live_count;
          end else begin
            for (int i = 0; i < CAP; i++)
              if (!hd_valid[i]) begin
                hd_valid[i] = 1'b1;
                hd_key[i] = w.value;
                hd_slot[i] = live_count;
                break;
              end
            slot_link[live_count] = SLOT_NONE;
            r.flag = 1'b1;
          end
          slot_val[live_count] = w.value;
          live_count++;
        end
      end
      smt_pkg::OP_REMOVE: begin
        h = head_of(w.value);
        if (h < CAP && live_count > 0) begin
          r.flag = 1'b1;
          hole = hd_slot[h];
          last = live_count - 1;
          older = slot_link[hole];
          if (older < CAP) hd_slot[h] = older;
          else hd_valid[h] = 1'b0;
          if (hole != last) begin
            for (int i = 0; i < CAP; i++)
              if (hd_valid[i] && hd_slot[i] == last) hd_slot[i] = hole;
            for (int i = 0; i < last; i++)
              if (i != hole && slot_link[i] == last) slot_link[i] = hole;
            slot_val[hole] = slot_val[last];
            slot_link[hole] = slot_link[last];
          end
          live_count = last;
        end
      end
      smt_pkg::OP_SAMPLE: begin
        if (live_count == 0) r.status = smt_pkg::ST_EMPTY;
        else r.sampled = slot_val[w.rnd % live_count];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Send one word at the falling edge and wait until it is taken.
  task automatic send_word(op_word_t w);
    @(negedge clk);
    while (!tx_no_idle && $urandom_range(99) < 34) @(negedge clk);
    in_tdata <= {6'b0, w};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // Accepted input words feed the predictor.
  always @(posedge clk) begin
    op_word_t w;
    if (rst_n && in_tvalid && in_tready) begin
      w = in_tdata[65:0];
      pending_results = {pending_results, multiset_apply(w)};
    end
  end

  // Result words are compared with the oldest expectation.
  always @(posedge clk) begin
    result_word_t got;
    result_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[34:0];
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", 32'(got), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (got.flag !== want.flag) report_mismatch("answer_flag", 32'(got.flag), 32'(want.flag));
        if (got.sampled !== want.sampled)
          report_mismatch("sampled_value", got.sampled, want.sampled);
        if (got.status !== want.status)
          report_mismatch("status", 32'(got.status), 32'(want.status));
      end
    end
  end

  // Receiver readiness, with random stalls and a commanded hold-off.
  always @(negedge clk) begin
    if (hold_off_rx) out_tready <= 1'b0;
    else out_tready <= rx_no_idle || ($urandom_range(99) >= 34);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic op_word_t mk(logic [1:0] op, logic [31:0] v, logic [31:0] r);
    op_word_t w;
    w.op = op;
    w.value = v;
    w.rnd = r;
    return w;
  endfunction

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Random word: mostly values from a small pool so removes find hits.
  function automatic op_word_t random_word(int fill_bias);
    logic [31:0] v;
    logic [1:0]  op;
    int pick;
    if ($urandom_range(9) == 0) v = $urandom();
    else v = 32'($urandom_range(15)) ^ {1'($urandom_range(1)), 31'd0};
    pick = $urandom_range(99);
    if (pick < fill_bias) op = smt_pkg::OP_INSERT;
    else if (pick < fill_bias + (96 - fill_bias) / 2) op = smt_pkg::OP_REMOVE;
    else if (pick < 98) op = smt_pkg::OP_SAMPLE;
    else op = OP_UNUSED;
    return mk(op, v, $urandom());
  endfunction

  // Held-off receiver counts its own cycles while the sender keeps going.
  task automatic long_hold_off();
    hold_off_rx = 1'b1;
    repeat (3000) @(posedge clk);
    hold_off_rx = 1'b0;
  endtask

  initial begin
    directed_row_t rows[$];
    directed_row_t row;
    result_word_t  want;
    op_word_t      w;

    for (int i = 0; i < CAP; i++) hd_valid[i] = 1'b0;
    live_count = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table: empty sample, extremes, absent remove, unused op.
    row.fixed = 1'b1;
    row.w = mk(smt_pkg::OP_SAMPLE, 32'd0, 32'hFFFF_FFFF);
    row.res = '{smt_pkg::ST_EMPTY, 32'd0, 1'b0};
    rows = {rows, row};
    row.w = mk(smt_pkg::OP_REMOVE, 32'd5, 32'd0);
    row.res = '{smt_pkg::ST_DONE, 32'd0, 1'b0};
    rows = {rows, row};
    row.w = mk(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    row.res = '{smt_pkg::ST_DONE, 32'd0, 1'b0};
    rows = {rows, row};
    row.w = mk(smt_pkg::OP_INSERT, 32'h8000_0000, 32'd0);
    row.res = '{smt_pkg::ST_DONE, 32'd0, 1'b1};
    rows = {rows, row};
    row.w = mk(smt_pkg::OP_SAMPLE, 32'd0, 32'hFFFF_FFFF);
    row.res = '{smt_pkg::ST_DONE, 32'h8000_0000, 1'b0};
    rows = {rows, row};
    row.w = mk(smt_pkg::OP_INSERT, 32'h7FFF_FFFF, 32'd0);
    row.res = '{smt_pkg::ST_DONE, 32'd0, 1'b1};
    rows = {rows, row};
    row.w = mk(smt_pkg::OP_INSERT, 32'h8000_0000, 32'd0);
    row.res = '{smt_pkg::ST_DONE, 32'd0, 1'b0};
    rows = {rows, row};
    row.fixed = 1'b0;
    row.w = mk(smt_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'd0); rows = {rows, row};
    row.w = mk(smt_pkg::OP_INSERT, 32'd0, 32'd0);        rows = {rows, row};
    row.w = mk(smt_pkg::OP_SAMPLE, 32'd0, 32'd0);        rows = {rows, row};
    row.w = mk(smt_pkg::OP_SAMPLE, 32'd0, 32'hFFFF_FFFF); rows = {rows, row};
    row.w = mk(smt_pkg::OP_SAMPLE, 32'd0, 32'hAAAA_5555); rows = {rows, row};
    row.w = mk(smt_pkg::OP_REMOVE, 32'h8000_0000, 32'd0); rows = {rows, row};
    row.w = mk(smt_pkg::OP_REMOVE, 32'h7FFF_FFFF, 32'd0); rows = {rows, row};
    row.w = mk(smt_pkg::OP_REMOVE, 32'h8000_0000, 32'd0); rows = {rows, row};
    row.w = mk(smt_pkg::OP_REMOVE, 32'h8000_0000, 32'd0); rows = {rows, row};
    row.w = mk(smt_pkg::OP_SAMPLE, 32'd0, 32'd7);        rows = {rows, row};

    tx_no_idle = 1'b1;
    foreach (rows[i]) begin
      if (rows[i].fixed) begin
        drain_results();
        want = rows[i].res;
        send_word(rows[i].w);
        // The word was just taken, so its expectation is the only one queued.
        if (pending_results.size() != 1 || pending_results[0] != want)
          report_mismatch("predictor row", 32'(pending_results[$]), 32'(want));
      end else begin
        send_word(rows[i].w);
      end
    end
    tx_no_idle = 1'b0;
    drain_results();

    // Fill to capacity, then two full-table inserts, then a sample.
    rx_no_idle = 1'b1;
    tx_no_idle = 1'b1;
    for (int k = live_count; k < CAP + 2; k++) begin
      w = random_word(100);
      send_word(mk(smt_pkg::OP_INSERT, w.value, w.rnd));
      drain_results();
    end
    send_word(mk(smt_pkg::OP_SAMPLE, 32'd0, 32'hFFFF_FFFF));
    rx_no_idle = 1'b0;
    tx_no_idle = 1'b0;

    // Receiver hold-off while words keep coming.
    fork
      long_hold_off();
      repeat (6) send_word(random_word(20));
    join
    drain_results();

    for (int i = 0; i < 6; i++) send_word(random_word(30));

    // Random phase: alternate growing and shrinking bias.
    for (int n = 0; n < 420; n++) begin
      if (n == 150) rx_no_idle = 1'b1;
      if (n == 230) rx_no_idle = 1'b0;
      send_word(random_word((n / 60) % 2 ? 25 : 60));
      if (n == 300) drain_results();
    end
    send_word(mk(smt_pkg::OP_SAMPLE, 32'd0, $urandom()));

    drain_results();
    repeat (1200) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
